// ===== rtl/ifrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifrt_pkg
// Types and constants shared by the fragment reassembly tracker.
// ----------------------------------------------------------------------------
package ifrt_pkg;
  localparam int Entries = 16;
  localparam int SlotW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int CntW = $clog2(Entries + 1);
  localparam logic [16:0] LenMax = 17'h1ffff;
  localparam logic [16:0] OffsetLimit = 17'h0ff00;
  localparam logic [7:0] LifetimeReset = 8'd60;

  localparam logic [2:0] StFirst = 3'd0;
  localparam logic [2:0] StLater = 3'd1;
  localparam logic [2:0] StComplete = 3'd2;
  localparam logic [2:0] StNoEntry = 3'd3;
  localparam logic [2:0] StDupFirst = 3'd4;
  localparam logic [2:0] StTooLarge = 3'd5;
  localparam logic [2:0] StFull = 3'd6;
  localparam logic [2:0] StTick = 3'd7;

  typedef struct packed {
    logic        action;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] ident;
    logic [12:0] frag_offset;
    logic        more_fragments;
    logic [5:0]  hdr_bytes;
    logic [15:0] total_len;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [16:0] write_offset;
    logic [15:0] copy_len;
    logic        copy_from_header;
    logic [16:0] assembled_len;
    logic [4:0]  expired_count;
  } out_req_t;

  // Entry record: key, ident, header length, length, age.
  localparam int RecW = 64 + 16 + 6 + 17 + 8;
endpackage
`default_nettype wire

// ===== rtl/ifrt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifrt_in_if / ifrt_out_if
// Valid/ready channels for fragment requests and result descriptors.
// ----------------------------------------------------------------------------
interface ifrt_in_if import ifrt_pkg::*; ();
  logic    valid;
  logic    ready;
  in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ifrt_out_if import ifrt_pkg::*; ();
  logic     valid;
  logic     ready;
  out_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ifrt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifrt_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ifrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/ipv4_fragment_reassembly_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_fragment_reassembly_tracker
// Tracks open IPv4 reassemblies and emits one result descriptor per request.
// ----------------------------------------------------------------------------
// Requests arrive on in_ (valid/ready). A fragment request carries the key,
// offset, flags and lengths; a tick request ages every open entry. Each
// request yields exactly one result on out_ (valid/ready).
// The entry record lives in a single-port RAM; a sequencer walks all
// entries through that one port and one shared key compare. A fragment
// then rereads and writes back the chosen entry; a tick writes back each
// aged valid entry in turn, through the same read-then-write RAM port.
// The block takes one request at a time and is not ready while working.
// The result is held in an output register until taken; while the receiver
// stalls, the block holds the result and does not accept a new request.
// cfg_we writes the lifetime register life_r at once. Reset empties the table by clearing
// the per-entry valid bits; the RAM itself needs no clearing pass.
// ----------------------------------------------------------------------------
module ipv4_fragment_reassembly_tracker import ifrt_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  ifrt_in_if.sink        in_ch,
  ifrt_out_if.source     out_ch,
  input wire logic       cfg_we,
  input wire logic [7:0] cfg_wdata
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_WRD  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_HRD  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [7:0]         life_r;
  logic [Entries-1:0] valid_r, valid_nxt;
  logic [SlotW-1:0]   idx_r, idx_nxt;
  logic               found_r, found_nxt, free_r, free_nxt;
  logic [SlotW-1:0]   hit_r, hit_nxt, free_idx_r, free_idx_nxt;
  logic [CntW-1:0]    exp_r, exp_nxt;
  in_req_t            req_r;
  out_req_t           res_r, res_nxt;

  logic               ram_we;
  logic [SlotW-1:0]   ram_addr;
  logic [RecW-1:0]    ram_wdata, ram_rdata;

  logic [63:0]        rd_key;
  logic [15:0]        rd_ident;
  logic [5:0]         rd_hl;
  logic [16:0]        rd_len;
  logic [7:0]         rd_age;
  logic [7:0]         age_inc;
  logic [16:0]        off8;
  logic [15:0]        pay;
  logic [17:0]        len_sum;
  logic [16:0]        len_sat;
  logic               last_idx;

  ifrt_ram #(.Width(RecW), .Depth(Entries)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign {rd_key, rd_ident, rd_hl, rd_len, rd_age} = ram_rdata;
  assign age_inc  = (rd_age == 8'hff) ? rd_age : rd_age + 8'd1;
  assign off8     = {1'b0, req_r.frag_offset, 3'b000};
  assign pay      = (req_r.total_len >= {10'd0, req_r.hdr_bytes}) ?
                    req_r.total_len - {10'd0, req_r.hdr_bytes} : 16'd0;
  assign len_sum  = {1'b0, rd_len} + {2'b00, pay};
  assign len_sat  = len_sum[17] ? LenMax : len_sum[16:0];
  assign last_idx = (idx_r == SlotW'(Entries - 1));

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = res_r;

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    idx_nxt      = idx_r;
    found_nxt    = found_r;
    free_nxt     = free_r;
    hit_nxt      = hit_r;
    free_idx_nxt = free_idx_r;
    exp_nxt      = exp_r;
    res_nxt      = res_r;
    ram_we       = 1'b0;
    ram_addr     = idx_r;
    ram_wdata    = ram_rdata;
    unique case (state_r)
      S_IDLE: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
        free_nxt  = 1'b0;
        exp_nxt   = '0;
        res_nxt   = '0;
        if (in_ch.valid) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (req_r.action) begin
          state_nxt = S_WRD;
        end else begin
          if (valid_r[idx_r] && !found_r && rd_key == {req_r.src_ip, req_r.dst_ip}
              && rd_ident == req_r.ident) begin
            found_nxt = 1'b1;
            hit_nxt   = idx_r;
          end
          if (!valid_r[idx_r] && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = idx_r;
          end
          if (last_idx) begin
            state_nxt = S_HRD;
            idx_nxt   = found_nxt ? hit_nxt : idx_r;
          end else begin
            idx_nxt   = idx_r + SlotW'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_HRD: begin
        state_nxt = S_UPD;
      end
      S_WRD: begin
        if (valid_r[idx_r]) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_key, rd_ident, rd_hl, rd_len, age_inc};
          if (age_inc >= life_r) begin
            valid_nxt[idx_r] = 1'b0;
            exp_nxt          = exp_r + CntW'(1);
          end
        end
        if (last_idx) begin
          res_nxt.status        = StTick;
          res_nxt.expired_count = 5'(exp_nxt);
          state_nxt             = S_OUT;
        end else begin
          idx_nxt   = idx_r + SlotW'(1);
          state_nxt = S_RD;
        end
      end
      S_UPD: begin
        // The registered read of the hit entry, issued in S_HRD, is valid in this state.
        state_nxt = S_OUT;
        if (off8 > OffsetLimit) begin
          res_nxt.status = StTooLarge;
          if (found_r) begin
            valid_nxt[hit_r] = 1'b0;
            res_nxt.slot     = 4'(hit_r);
          end
        end else if (req_r.frag_offset != '0) begin
          if (!found_r) begin
            res_nxt.status = StNoEntry;
          end else begin
            ram_we                = 1'b1;
            ram_wdata             = {rd_key, rd_ident, rd_hl, len_sat, rd_age};
            res_nxt.slot          = 4'(hit_r);
            res_nxt.write_offset  = off8 + {11'd0, rd_hl};
            res_nxt.copy_len      = pay;
            res_nxt.assembled_len = len_sat;
            res_nxt.status        = req_r.more_fragments ? StLater : StComplete;
            if (!req_r.more_fragments) begin
              valid_nxt[hit_r] = 1'b0;
            end
          end
        end else if (found_r) begin
          res_nxt.status = StDupFirst;
          res_nxt.slot   = 4'(hit_r);
        end else if (!free_r) begin
          res_nxt.status = StFull;
        end else begin
          ram_addr  = free_idx_r;
          ram_we    = 1'b1;
          ram_wdata = {req_r.src_ip, req_r.dst_ip, req_r.ident, req_r.hdr_bytes,
                       {1'b0, req_r.total_len}, 8'd0};
          res_nxt.slot             = 4'(free_idx_r);
          res_nxt.copy_len         = req_r.total_len;
          res_nxt.copy_from_header = 1'b1;
          res_nxt.assembled_len    = {1'b0, req_r.total_len};
          res_nxt.status           = req_r.more_fragments ? StFirst : StComplete;
          valid_nxt[free_idx_r]    = req_r.more_fragments;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      life_r  <= LifetimeReset;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      if (cfg_we) begin
        life_r <= cfg_wdata;
      end
    end
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    free_r     <= free_nxt;
    hit_r      <= hit_nxt;
    free_idx_r <= free_idx_nxt;
    exp_r      <= exp_nxt;
    res_r      <= res_nxt;
    if (in_ch.valid && in_ch.ready) begin
      req_r <= in_ch.data;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed while stalled");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("ready while result pending");
  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.status != StTick |-> out_ch.data.expired_count == 5'd0)
    else $error("expired count on fragment result");
endmodule
`default_nettype wire

// ===== bench/tb_ipv4_fragment_reassembly_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_fragment_reassembly_tracker
// Self-checking bench for the IPv4 fragment reassembly tracker.
// ----------------------------------------------------------------------------
// A table model inside a small scoreboard class predicts one descriptor per
// request. Directed requests cover first, later, last, duplicate, too large,
// no entry, table full, single fragment, short packet and ticks. Random
// requests then run well-formed fragment trains over a small key pool, with
// noise. Both channels idle at random, and the lifetime register is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_ipv4_fragment_reassembly_tracker;
  import ifrt_pkg::*;

  class reassembly_scoreboard;
    bit          valid_q [16];
    bit   [63:0] key_q [16];
    bit   [15:0] id_q [16];
    bit   [5:0]  hl_q [16];
    bit   [16:0] len_q [16];
    bit   [7:0]  age_q [16];
    bit   [7:0]  lifetime;
    out_req_t    pending[$];
    int          errors;

    function new();
      lifetime = LifetimeReset;
      errors = 0;
      foreach (valid_q[i]) valid_q[i] = 0;
    endfunction

    function void note_request(in_req_t r);
      out_req_t o;
      int s;
      int f;
      bit [63:0] key;
      bit [16:0] pay;
      bit [17:0] sum;
      o = '0;
      s = -1;
      f = -1;
      key = {r.src_ip, r.dst_ip};
      pay = (r.total_len >= 16'(r.hdr_bytes)) ? 17'(r.total_len - 16'(r.hdr_bytes)) : 17'd0;
      if (r.action) begin
        for (int i = 0; i < 16; i++) begin
          if (valid_q[i]) begin
            if (age_q[i] != 8'hff) age_q[i]++;
            if (age_q[i] >= lifetime) begin
              valid_q[i] = 0;
              o.expired_count++;
            end
          end
        end
        o.status = StTick;
      end else begin
        for (int i = 15; i >= 0; i--) begin
          if (valid_q[i] && key_q[i] == key && id_q[i] == r.ident) s = i;
          if (!valid_q[i]) f = i;
        end
        if ({1'b0, r.frag_offset, 3'b000} > OffsetLimit) begin
          if (s >= 0) begin
            valid_q[s] = 0;
            o.slot = 4'(s);
          end
          o.status = StTooLarge;
        end else if (r.frag_offset != 0) begin
          if (s < 0) begin
            o.status = StNoEntry;
          end else begin
            sum = {1'b0, len_q[s]} + {1'b0, pay};
            len_q[s] = (sum > {1'b0, LenMax}) ? LenMax : sum[16:0];
            o.slot = 4'(s);
            o.write_offset = {1'b0, r.frag_offset, 3'b000} + {11'd0, hl_q[s]};
            o.copy_len = pay[15:0];
            o.assembled_len = len_q[s];
            o.status = r.more_fragments ? StLater : StComplete;
            if (!r.more_fragments) valid_q[s] = 0;
          end
        end else if (s >= 0) begin
          o.status = StDupFirst;
          o.slot = 4'(s);
        end else if (f < 0) begin
          o.status = StFull;
        end else begin
          valid_q[f] = r.more_fragments;
          key_q[f] = key;
          id_q[f] = r.ident;
          hl_q[f] = r.hdr_bytes;
          len_q[f] = {1'b0, r.total_len};
          age_q[f] = 0;
          o.slot = 4'(f);
          o.copy_len = r.total_len;
          o.copy_from_header = 1;
          o.assembled_len = {1'b0, r.total_len};
          o.status = r.more_fragments ? StFirst : StComplete;
        end
      end
      pending.push_back(o);
    endfunction

    function void check_result(out_req_t a);
      out_req_t e;
      if (pending.size() == 0) begin
        $error("result with no request waiting: %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status != e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.slot != e.slot) begin
        $error("slot exp %0d got %0d", e.slot, a.slot); errors++;
      end
      if (a.write_offset != e.write_offset) begin
        $error("write_offset exp %0d got %0d", e.write_offset, a.write_offset); errors++;
      end
      if (a.copy_len != e.copy_len) begin
        $error("copy_len exp %0d got %0d", e.copy_len, a.copy_len); errors++;
      end
      if (a.copy_from_header != e.copy_from_header) begin
        $error("copy_from_header exp %0d got %0d", e.copy_from_header,
               a.copy_from_header); errors++;
      end
      if (a.assembled_len != e.assembled_len) begin
        $error("assembled_len exp %0d got %0d", e.assembled_len, a.assembled_len);
        errors++;
      end
      if (a.expired_count != e.expired_count) begin
        $error("expired_count exp %0d got %0d", e.expired_count, a.expired_count);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         idle_cycles;
  bit         stim_done;
  reassembly_scoreboard sb;
  bit  [31:0] pool_src [4];
  bit  [31:0] pool_dst [4];
  bit  [15:0] pool_id [4];

  ifrt_in_if  in_ch ();
  ifrt_out_if out_ch ();

  ipv4_fragment_reassembly_tracker dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic send_request(in_req_t r);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data = r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_frag(bit [31:0] s, bit [31:0] d, bit [15:0] id, bit [12:0] off,
                           bit mf, bit [5:0] hl, bit [15:0] tl);
    in_req_t r;
    r = '0;
    r.src_ip = s; r.dst_ip = d; r.ident = id; r.frag_offset = off;
    r.more_fragments = mf; r.hdr_bytes = hl; r.total_len = tl;
    send_request(r);
  endtask

  task automatic send_tick();
    in_req_t r;
    r = in_req_t'(117'({$urandom, $urandom, $urandom, $urandom}));
    r.action = 1'b1;
    send_request(r);
  endtask

  task automatic write_lifetime(bit [7:0] v);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.lifetime = v;
  endtask

  task automatic random_frag();
    int p;
    bit [5:0] hl;
    p = $urandom_range(0, 3);
    hl = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(20, 60));
    case ($urandom_range(0, 9))
      0: send_frag($urandom, $urandom, 16'($urandom), 13'($urandom), 1'($urandom), hl,
                   16'($urandom));
      1: send_frag(pool_src[p], pool_dst[p], pool_id[p], 13'($urandom_range(8000, 8191)),
                   1'($urandom), hl, 16'($urandom));
      2, 3: send_frag(pool_src[p], pool_dst[p], pool_id[p], 13'd0,
                      $urandom_range(0, 5) != 0, hl, 16'($urandom_range(0, 1500)));
      default: send_frag(pool_src[p], pool_dst[p], pool_id[p],
                         13'($urandom_range(1, 8160)),
                         $urandom_range(0, 3) != 0, hl,
                         ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                         16'($urandom_range(0, 1500)));
    endcase
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    in_ch.valid = 0;
    in_ch.data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send_frag(32'h0a000001, 32'h0a000002, 16'h1234, 0, 1, 20, 1500);
    send_frag(32'h0a000001, 32'h0a000002, 16'h1234, 0, 1, 20, 1500);
    send_frag(32'h0a000001, 32'h0a000002, 16'h1234, 185, 1, 20, 1500);
    send_frag(32'h0a000001, 32'h0a000002, 16'h1234, 370, 0, 20, 10);
    send_frag(32'h0a000001, 32'h0a000002, 16'h1234, 370, 0, 20, 10);
    send_frag(32'hffffffff, 32'hffffffff, 16'hffff, 0, 0, 60, 16'hffff);
    send_frag(32'h0, 32'h0, 16'h0, 0, 1, 60, 16'hffff);
    send_frag(32'h0, 32'h0, 16'h0, 8160, 1, 60, 16'hffff);
    send_frag(32'h0, 32'h0, 16'h0, 8160, 1, 63, 16'hffff);
    send_frag(32'h0, 32'h0, 16'h0, 8161, 1, 20, 100);
    send_frag(32'h0, 32'h0, 16'h0, 8191, 0, 20, 100);
    send_frag(32'h5, 32'h6, 16'h7, 0, 1, 40, 10);
    send_frag(32'h5, 32'h6, 16'h7, 1, 0, 40, 10);
    for (int i = 0; i < 17; i++) send_frag(32'h100 + i, 32'h1, 16'h2, 0, 1, 20, 100);
    write_lifetime(8'd1);
    send_tick();
    write_lifetime(8'd255);

    for (int i = 0; i < 4; i++) begin
      pool_src[i] = $urandom; pool_dst[i] = $urandom; pool_id[i] = 16'($urandom);
    end
    pool_dst[1] = pool_dst[0];
    pool_src[2] = pool_src[0]; pool_dst[2] = pool_dst[0];
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: write_lifetime(8'd0);
        2: write_lifetime(8'd3);
        3: write_lifetime(8'($urandom_range(1, 255)));
        4: write_lifetime(8'd60);
        default: ;
      endcase
      for (int n = 0; n < 120; n++) begin
        if ($urandom_range(0, 9) == 0) send_tick();
        else random_frag();
        if ($urandom_range(0, 29) == 0) begin
          pool_src[$urandom_range(0, 3)] = $urandom;
          pool_id[$urandom_range(0, 3)] = 16'($urandom);
        end
      end
    end
    stim_done = 1;
  end

  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 1) == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        repeat (gap_len() + 1) @(negedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("[ipv4_fragment_reassembly_tracker] ERROR");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ipv4_fragment_reassembly_tracker] OK");
    else
      $display("[ipv4_fragment_reassembly_tracker] ERROR");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/ifrt_pkg.sv
rtl/ifrt_if.sv
rtl/ifrt_ram.sv
rtl/ipv4_fragment_reassembly_tracker.sv
bench/tb_ipv4_fragment_reassembly_tracker.sv
